// ===== rtl/gww_pkg.sv =====
// Package with the shared types and constants of the greedy word wrapper.
package gww_pkg;

    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [1:0] PARAGRAPH_RUN = 2'd2;
    localparam logic [1:0] NL_RUN_MAX    = 2'd3;

    localparam int unsigned LINE_W_BITS  = 10;
    localparam logic [LINE_W_BITS-1:0] LINE_WIDTH_RESET = 10'd80;

    typedef enum logic {
        CMD_TEXT  = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PRE,
        S_READ,
        S_EMIT,
        S_TAIL
    } t_state;

endpackage

// ===== rtl/gww_in_if.sv =====
// Input channel interface: one text byte or flush command per item.
interface gww_in_if;
    import gww_pkg::*;

    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] text_byte;

    modport source (output valid, output command, output text_byte, input ready);
    modport sink   (input valid, input command, input text_byte, output ready);
endinterface

// ===== rtl/gww_out_if.sv =====
// Output channel interface: one emitted character with its status bits per item.
interface gww_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       width_exceeded;
    logic       word_truncated;

    modport source (output valid, output out_byte, output last, output width_exceeded,
                    output word_truncated, input ready);
    modport sink   (input valid, input out_byte, input last, input width_exceeded,
                    input word_truncated, output ready);
endinterface

// ===== rtl/greedy_word_wrapper.sv =====
// Greedy word wrapper: text bytes in, wrapped text out, word replayed from a buffer memory.
// A word byte is taken and goes into the word buffer; nothing is emitted then.
// A separator or flush item is taken; the sequencer then works through its results: prefix space or
// newline, each word byte (buffer read, then emit) and tail newlines, each emit waiting for output room.
// The next item is taken once the sequencer is back in idle; the output register decouples.
// Reset (synchronous, active low) clears control state and flags; line_width returns to 80.
module greedy_word_wrapper
    import gww_pkg::*;
#(
    parameter int unsigned MAX_WORD = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [LINE_W_BITS-1:0] i_cfg_wdata,
    gww_in_if.sink                 i_text,
    gww_out_if.source              o_wrap
);

    localparam int unsigned WL_W = $clog2(MAX_WORD + 1);
    localparam int unsigned AW   = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
    localparam logic [WL_W-1:0] WL_MAX = WL_W'(MAX_WORD);

    logic [LINE_W_BITS-1:0] r_line_width;
    logic [WL_W-1:0]        r_word_len, n_word_len;
    logic [LINE_W_BITS-1:0] r_line_len, n_line_len;
    logic [1:0]             r_nl_run, n_nl_run;
    logic                   r_in_sep, n_in_sep;
    logic                   r_too_long, n_too_long;
    logic                   r_truncated, n_truncated;

    t_state                 r_state, n_state;
    logic [WL_W-1:0]        r_emit_len;
    logic [AW-1:0]          r_idx;
    logic [1:0]             r_tail, n_tail;
    logic [7:0]             r_pfx_byte;

    logic                   r_out_valid;
    logic [7:0]             r_out_byte;
    logic                   r_out_last;
    logic                   r_out_wexc;
    logic                   r_out_trunc;

    logic                   w_acc;
    logic                   w_flush, w_space, w_nl, w_char;
    logic                   w_place, w_has_word, w_fits, w_pfx;
    logic [LINE_W_BITS:0]   w_sum;
    logic [LINE_W_BITS-1:0] w_ll_place;
    logic [1:0]             w_nr_inc;
    logic                   w_mem_we;

    logic                   w_slot, w_push, w_push_last, w_rd_en, w_word_end;
    logic [7:0]             w_push_byte;
    logic [7:0]             w_rd_data;

    assign w_acc   = i_text.valid && i_text.ready;
    assign w_flush = (i_text.command == CMD_FLUSH);
    assign w_space = !w_flush && (i_text.text_byte == CH_SPACE);
    assign w_nl    = !w_flush && (i_text.text_byte == CH_NEWLINE);
    assign w_char  = !w_flush && !w_space && !w_nl;

    // Placing the pending word: decide prefix and the line length after it.
    assign w_has_word = (r_word_len != '0);
    assign w_sum      = {1'b0, r_line_len} + (LINE_W_BITS+1)'(r_word_len);
    assign w_fits     = w_sum < {1'b0, r_line_width};
    assign w_pfx      = w_has_word && (r_line_len != '0);
    assign w_nr_inc   = (r_nl_run == NL_RUN_MAX) ? NL_RUN_MAX : r_nl_run + 2'd1;
    assign w_place    = w_flush || (w_space && !r_in_sep) || w_nl;

    always_comb begin
        if (!w_has_word) begin
            w_ll_place = r_line_len;
        end else if (r_line_len != '0 && w_fits) begin
            w_ll_place = w_sum[LINE_W_BITS-1:0] + LINE_W_BITS'(1);
        end else begin
            w_ll_place = LINE_W_BITS'(r_word_len);
        end
    end

    always_comb begin
        n_word_len  = r_word_len;
        n_line_len  = r_line_len;
        n_nl_run    = r_nl_run;
        n_in_sep    = r_in_sep;
        n_too_long  = r_too_long;
        n_truncated = r_truncated;
        n_tail      = 2'd0;
        w_mem_we    = 1'b0;
        if (w_place) begin
            n_word_len = '0;
            n_line_len = w_ll_place;
            if (w_has_word && ((LINE_W_BITS+1)'(r_word_len) > {1'b0, r_line_width})) begin
                n_too_long = 1'b1;
            end
        end
        if (w_flush) begin
            n_tail     = (w_ll_place != '0) ? 2'd1 : 2'd0;
            n_line_len = '0;
            n_nl_run   = 2'd0;
            n_in_sep   = 1'b0;
        end else if (w_space) begin
            if (!r_in_sep) begin
                n_in_sep = 1'b1;
                n_nl_run = 2'd0;
            end
        end else if (w_nl) begin
            n_in_sep = 1'b0;
            n_nl_run = w_nr_inc;
            if (w_nr_inc == PARAGRAPH_RUN) begin
                n_tail     = (w_ll_place != '0) ? 2'd2 : 2'd1;
                n_line_len = '0;
            end
        end else begin
            n_nl_run = 2'd0;
            n_in_sep = 1'b0;
            if (r_word_len < WL_MAX) begin
                w_mem_we   = 1'b1;
                n_word_len = r_word_len + WL_W'(1);
            end else begin
                n_truncated = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= LINE_WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_line_width <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_len  <= '0;
            r_line_len  <= '0;
            r_nl_run    <= 2'd0;
            r_in_sep    <= 1'b0;
            r_too_long  <= 1'b0;
            r_truncated <= 1'b0;
        end else if (w_acc) begin
            r_word_len  <= n_word_len;
            r_line_len  <= n_line_len;
            r_nl_run    <= n_nl_run;
            r_in_sep    <= n_in_sep;
            r_too_long  <= n_too_long;
            r_truncated <= n_truncated;
        end
    end

    gww_word_buf #(
        .DEPTH (MAX_WORD),
        .AW    (AW)
    ) u_word_buf (
        .i_clk     (i_clk),
        .i_wr_en   (w_acc && w_mem_we),
        .i_wr_addr (r_word_len[AW-1:0]),
        .i_wr_data (i_text.text_byte),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_idx),
        .o_rd_data (w_rd_data)
    );

    // Sequencer: prefix, then each word byte as read then emit, then tail newlines.
    assign w_slot     = !r_out_valid || o_wrap.ready;
    assign w_word_end = (WL_W'(r_idx) + WL_W'(1)) == r_emit_len;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && w_place && w_has_word) begin
                    n_state = w_pfx ? S_PRE : S_READ;
                end else if (w_acc && n_tail != 2'd0) begin
                    n_state = S_TAIL;
                end
            end
            S_PRE: begin
                if (w_slot) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot) begin
                    if (!w_word_end) begin
                        n_state = S_READ;
                    end else if (r_tail != 2'd0) begin
                        n_state = S_TAIL;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_TAIL: begin
                if (w_slot && r_tail == 2'd1) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_push      = 1'b0;
        w_push_byte = CH_NEWLINE;
        w_push_last = 1'b0;
        w_rd_en     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
            end
            S_PRE: begin
                w_push      = w_slot;
                w_push_byte = r_pfx_byte;
            end
            S_READ: begin
                w_rd_en = 1'b1;
            end
            S_EMIT: begin
                w_push      = w_slot;
                w_push_byte = w_rd_data;
                w_push_last = w_word_end && (r_tail == 2'd0);
            end
            S_TAIL: begin
                w_push      = w_slot;
                w_push_last = (r_tail == 2'd1);
            end
            default: begin
            end
        endcase
    end

    assign i_text.ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tail  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (w_acc) begin
                r_tail <= n_tail;
            end else if (r_state == S_TAIL && w_slot) begin
                r_tail <= r_tail - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_emit_len <= r_word_len;
            r_idx      <= '0;
            r_pfx_byte <= w_fits ? CH_SPACE : CH_NEWLINE;
        end else if (r_state == S_EMIT && w_slot && !w_word_end) begin
            r_idx <= r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot) begin
            r_out_valid <= w_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_byte  <= w_push_byte;
            r_out_last  <= w_push_last;
            r_out_wexc  <= r_too_long;
            r_out_trunc <= r_truncated;
        end
    end

    assign o_wrap.valid          = r_out_valid;
    assign o_wrap.out_byte       = r_out_byte;
    assign o_wrap.last           = r_out_last;
    assign o_wrap.width_exceeded = r_out_wexc;
    assign o_wrap.word_truncated = r_out_trunc;

    a_word_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_word_len <= WL_MAX)
        else $error("word length beyond buffer depth");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && w_push_last |=> r_state == S_IDLE)
        else $error("sequencer busy after last result of an item");

    a_emit_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_EMIT) |-> WL_W'(r_idx) < r_emit_len)
        else $error("word replay index past word length");

    a_char_no_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_char |=> r_state == S_IDLE)
        else $error("word byte started output");

endmodule

// ===== rtl/gww_word_buf.sv =====
// Word buffer memory: one write port and one registered read port.
module gww_word_buf #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the greedy word wrapper: directed and random text in, wrapped text checked.
module tb_top;
    import gww_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WORD_MAX      = 32;
    localparam int SETTLE_CYCLES = 120;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] ch;
    } t_text_item;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       wexc;
        logic       wtrunc;
    } t_wrap_out;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_COIN,
        STALL_PERIODIC,
        STALL_SPARSE
    } t_stall;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [LINE_W_BITS-1:0] i_cfg_wdata = '0;

    gww_in_if  text_if ();
    gww_out_if wrap_if ();

    greedy_word_wrapper #(
        .MAX_WORD(WORD_MAX)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_text     (text_if),
        .o_wrap     (wrap_if)
    );

    always #5 i_clk = ~i_clk;

    // Text items waiting to be sent, and wrapped characters waiting to come out.
    t_text_item text_q[$];
    t_wrap_out  wrap_expect_q[$];
    int         n_errors = 0;

    // Shadow copy of the wrapper state.
    logic [7:0]             word_mem[WORD_MAX];
    int unsigned            word_len;
    int unsigned            line_len;
    int unsigned            nl_run;
    bit                     in_sep;
    bit                     too_long;
    bit                     cut_flag;
    logic [LINE_W_BITS-1:0] width_m;
    logic [7:0]             emit_q[$];

    task automatic place_pending_word();
        if (word_len == 0)
            return;
        if (word_len > width_m)
            too_long = 1'b1;
        if (line_len > 0) begin
            if (line_len + word_len < width_m) begin
                emit_q.push_back(CH_SPACE);
                line_len = (line_len + word_len + 1) & 'h3FF;
            end else begin
                emit_q.push_back(CH_NEWLINE);
                line_len = word_len;
            end
        end else begin
            line_len = word_len;
        end
        for (int i = 0; i < word_len; i++)
            emit_q.push_back(word_mem[i]);
        word_len = 0;
    endtask

    task automatic wrap_item(input t_cmd cmd, input logic [7:0] b);
        emit_q.delete();
        if (cmd == CMD_FLUSH) begin
            place_pending_word();
            if (line_len > 0)
                emit_q.push_back(CH_NEWLINE);
            line_len = 0;
            nl_run   = 0;
            in_sep   = 1'b0;
        end else if (b == CH_SPACE) begin
            if (!in_sep) begin
                place_pending_word();
                in_sep = 1'b1;
                nl_run = 0;
            end
        end else if (b == CH_NEWLINE) begin
            place_pending_word();
            in_sep = 1'b0;
            if (nl_run < NL_RUN_MAX)
                nl_run++;
            if (nl_run == PARAGRAPH_RUN) begin
                if (line_len > 0)
                    emit_q.push_back(CH_NEWLINE);
                line_len = 0;
                emit_q.push_back(CH_NEWLINE);
            end
        end else begin
            nl_run = 0;
            in_sep = 1'b0;
            if (word_len < WORD_MAX) begin
                word_mem[word_len] = b;
                word_len++;
            end else begin
                cut_flag = 1'b1;
            end
        end
        for (int k = 0; k < emit_q.size(); k++)
            wrap_expect_q.push_back('{emit_q[k], k == emit_q.size() - 1, too_long, cut_flag});
    endtask

    // Compare outgoing characters first, then predict from the item taken at this edge.
    always @(posedge i_clk) begin : wrap_check
        t_wrap_out exp_r;
        if (!i_rst_n) begin
            word_len = 0;
            line_len = 0;
            nl_run   = 0;
            in_sep   = 1'b0;
            too_long = 1'b0;
            cut_flag = 1'b0;
            width_m  = LINE_WIDTH_RESET;
            wrap_expect_q.delete();
        end else begin
            if (i_cfg_we)
                width_m = i_cfg_wdata;
            if (wrap_if.valid && wrap_if.ready) begin
                if (wrap_expect_q.size() == 0) begin
                    $display("%0t ns: unexpected output, expected none, actual byte %02h",
                             $time, wrap_if.out_byte);
                    n_errors++;
                end else begin
                    exp_r = wrap_expect_q.pop_front();
                    if (wrap_if.out_byte !== exp_r.ch) begin
                        $display("%0t ns: out_byte expected %02h, actual %02h",
                                 $time, exp_r.ch, wrap_if.out_byte);
                        n_errors++;
                    end
                    if (wrap_if.last !== exp_r.last) begin
                        $display("%0t ns: last expected %b, actual %b",
                                 $time, exp_r.last, wrap_if.last);
                        n_errors++;
                    end
                    if (wrap_if.width_exceeded !== exp_r.wexc) begin
                        $display("%0t ns: width_exceeded expected %b, actual %b",
                                 $time, exp_r.wexc, wrap_if.width_exceeded);
                        n_errors++;
                    end
                    if (wrap_if.word_truncated !== exp_r.wtrunc) begin
                        $display("%0t ns: word_truncated expected %b, actual %b",
                                 $time, exp_r.wtrunc, wrap_if.word_truncated);
                        n_errors++;
                    end
                end
            end
            if (text_if.valid && text_if.ready)
                wrap_item(t_cmd'(text_if.command), text_if.text_byte);
        end
    end

    // Sender: bursts of back-to-back items separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin : text_drive
        t_text_item item;
        if (!i_rst_n) begin
            text_if.valid <= 1'b0;
        end else if (!text_if.valid || text_if.ready) begin
            if (gap_left > 0) begin
                gap_left--;
                text_if.valid <= 1'b0;
            end else if (text_q.size() > 0) begin
                item = text_q.pop_front();
                text_if.valid     <= 1'b1;
                text_if.command   <= item.cmd;
                text_if.text_byte <= item.ch;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                text_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: back-pressure pattern is picked at random from four stall modes and changes at random intervals.
    t_stall      stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int unsigned stall_tick = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wrap_if.ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode = t_stall'($urandom_range(0, 3));
                mode_left  = $urandom_range(20, 80);
            end else begin
                mode_left--;
            end
            stall_tick++;
            case (stall_mode)
                STALL_NONE:     wrap_if.ready <= 1'b1;
                STALL_COIN:     wrap_if.ready <= 1'($urandom_range(0, 1));
                STALL_PERIODIC: wrap_if.ready <= (stall_tick % 4 == 0);
                default:        wrap_if.ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic push_byte(input logic [7:0] b);
        text_q.push_back('{CMD_TEXT, b});
    endtask

    task automatic push_flush();
        text_q.push_back('{CMD_FLUSH, 8'($urandom_range(0, 255))});
    endtask

    function automatic logic [7:0] word_char();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_SPACE || b == CH_NEWLINE);
        return b;
    endfunction

    // Well-formed text: words with random content and a mix of separator runs.
    task automatic push_text(input int n_words, input int max_len);
        int len;
        for (int w = 0; w < n_words; w++) begin
            if ($urandom_range(0, 29) == 0)
                len = $urandom_range(WORD_MAX + 1, WORD_MAX + 6);
            else
                len = $urandom_range(1, max_len);
            repeat (len) push_byte(word_char());
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: push_byte(CH_SPACE);
                6: repeat ($urandom_range(2, 4)) push_byte(CH_SPACE);
                7: push_byte(CH_NEWLINE);
                8: repeat (2) push_byte(CH_NEWLINE);
                default: begin
                    push_byte(CH_SPACE);
                    repeat ($urandom_range(1, 3)) push_byte(CH_NEWLINE);
                end
            endcase
            if ($urandom_range(0, 11) == 0)
                push_flush();
        end
        push_flush();
    endtask

    // Unstructured items: separators, flushes and arbitrary bytes.
    task automatic push_noise(input int n);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 7))
                0:       push_flush();
                1, 2:    push_byte(CH_SPACE);
                3, 4:    push_byte(CH_NEWLINE);
                default: push_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    task automatic wait_drained();
        while (text_q.size() != 0 || text_if.valid || wrap_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_line_width(input logic [LINE_W_BITS-1:0] w);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        text_if.valid     = 1'b0;
        text_if.command   = 1'b0;
        text_if.text_byte = 8'h00;
        wrap_if.ready     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed text at the reset width: extreme bytes, separator runs, empty lines.
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(CH_SPACE);
        push_byte(CH_SPACE);
        push_byte("a");
        push_byte(CH_NEWLINE);
        push_byte(CH_NEWLINE);
        push_byte(CH_NEWLINE);
        push_byte("b");
        push_byte(CH_SPACE);
        push_byte(CH_NEWLINE);
        push_flush();
        push_flush();
        push_byte(CH_NEWLINE);
        push_byte(CH_NEWLINE);
        push_byte("c");
        push_flush();

        // Words wider than the line.
        set_line_width(10'd1);
        push_byte("x");
        push_byte("y");
        push_byte(CH_SPACE);
        push_byte("z");
        push_flush();

        // Zero width, with one word that overflows the buffer.
        set_line_width(10'd0);
        repeat (WORD_MAX + 3) push_byte(word_char());
        push_byte(CH_SPACE);
        push_text(6, 4);

        set_line_width(10'd1023);
        push_text(10, 8);

        set_line_width(10'd10);
        push_text(10, 8);
        // Let the output run dry before sending more.
        wait_drained();
        push_noise(30);
        push_text(6, 12);

        set_line_width(10'($urandom_range(1, 40)));
        push_text(8, 10);
        push_noise(20);

        set_line_width(10'($urandom_range(1, 1023)));
        push_text(6, 10);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_errors == 0 && wrap_expect_q.size() == 0) begin
            $display("greedy_word_wrapper test passed");
        end else begin
            $display("greedy_word_wrapper test failed");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("greedy_word_wrapper test failed");
        $finish;
    end

endmodule
